@@ design/graph_m_coloring_backtrack_assert.svh @@
// ----------------------------------------------------------------------------
// graph_m_coloring_backtrack assertion macros
// Shorthand for clocked, reset-qualified concurrent checks.
// ----------------------------------------------------------------------------
`ifndef GRAPH_M_COLORING_BACKTRACK_ASSERT_SVH
`define GRAPH_M_COLORING_BACKTRACK_ASSERT_SVH

// Same-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GMCB_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off while rst_ni is low.
`define GMCB_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ design/gmcb_pkg.sv @@
// ----------------------------------------------------------------------------
// gmcb_pkg
// Shared sizes and state codes of the graph m-coloring search block.
// ----------------------------------------------------------------------------
package gmcb_pkg;

  localparam int MaxVertices = 16;
  localparam int VtxAddrW    = $clog2(MaxVertices);
  localparam int RowW        = 16;
  localparam int ColorW      = 5;
  localparam int CountW      = 5;
  localparam int NumColors   = 1 << ColorW;
  localparam int CfgIdxW     = 1;

  localparam int InDataW     = 24;
  localparam int OutDataW    = 16;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] RegVertexCount = 1'd0;
  localparam logic [CfgIdxW-1:0] RegColorCount  = 1'd1;

  localparam logic [CountW-1:0] VertexCountRst = 5'd4;
  localparam logic [CountW-1:0] ColorCountRst  = 5'd3;

  // Sequencer states
  localparam int StW = 3;
  localparam logic [StW-1:0] StLoad  = 3'd0;
  localparam logic [StW-1:0] StClear = 3'd1;
  localparam logic [StW-1:0] StEnter = 3'd2;
  localparam logic [StW-1:0] StFetch = 3'd3;
  localparam logic [StW-1:0] StScan  = 3'd4;
  localparam logic [StW-1:0] StPick  = 3'd5;
  localparam logic [StW-1:0] StORead = 3'd6;
  localparam logic [StW-1:0] StOLoad = 3'd7;

endpackage

@@ design/gmcb_ram.sv @@
// ----------------------------------------------------------------------------
// gmcb_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module gmcb_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ design/graph_m_coloring_backtrack.sv @@
// ----------------------------------------------------------------------------
// graph_m_coloring_backtrack
// Stores an adjacency matrix row by row, then searches for an m-coloring by
// depth-first backtracking and streams out each vertex's color.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one adjacency row per beat (tdata: row_index, row_bits;
//   tlast: last_row). Rows are taken one per cycle. The beat with tlast set
//   stores its row and starts the search; s_axis_tready stays low until
//   every result of that search has been loaded into the output register.
//   Search steps: the whole color memory is cleared, then every vertex
//   visit reads, scans all V vertices with one color-memory read each and
//   picks, bounded by the color memory's single read port.
//   m_axis gives one beat per vertex (tdata: vertex, color; tuser: solved;
//   tlast on vertex V-1), each read from color memory and then loaded, or a single beat with solved
//   low and tlast high when no coloring exists. A stalled m_axis holds the
//   output register and the sequencer waits on it; a new row may be taken
//   while the final beat is still waiting.
//   cfg writes (index 0: vertex_count, index 1: color_count) are always
//   accepted and meant for idle periods only.
//   Reset sets vertex_count to 4, color_count to 3 and empties the output.
// ----------------------------------------------------------------------------
module graph_m_coloring_backtrack (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // row_index [3:0], row_bits [19:4], zero fill [23:20]
  input  logic [gmcb_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                           s_axis_tlast,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // vertex [3:0], color [8:4], zero fill [15:9]
  output logic [gmcb_pkg::OutDataW-1:0]  m_axis_tdata,
  // solved [0]
  output logic                           m_axis_tuser,
  output logic                           m_axis_tlast,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [gmcb_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gmcb_pkg::CountW-1:0]    cfg_data_i
);

  import gmcb_pkg::*;

  localparam logic [VtxAddrW-1:0] VtxLast = VtxAddrW'(MaxVertices - 1);

  logic [StW-1:0]      state_q, state_d;
  logic [CountW-1:0]   vertex_count_q, color_count_q;
  logic [CountW-1:0]   n_q, n_d;
  logic [CountW-1:0]   v_q, v_d;
  logic [VtxAddrW-1:0] i_q, i_d;
  logic [VtxAddrW-1:0] k_q, k_d;
  logic [RowW-1:0]     row_q, row_d;
  logic [ColorW:0]     start_q, start_d;
  logic [NumColors-1:0] forbid_q, forbid_d;
  logic                solved_q, solved_d;

  logic                out_valid_q, out_valid_d;
  logic [VtxAddrW-1:0] out_vertex_q, out_vertex_d;
  logic [ColorW-1:0]   out_color_q, out_color_d;
  logic                out_solved_q, out_solved_d;
  logic                out_last_q, out_last_d;

  logic                in_fire;
  logic [VtxAddrW-1:0] in_row_index;
  logic [RowW-1:0]     in_row_bits;
  logic [CountW-1:0]   n_sat;

  logic                adj_we;
  logic [VtxAddrW-1:0] adj_raddr;
  logic [RowW-1:0]     adj_rdata;
  logic                col_we;
  logic [VtxAddrW-1:0] col_waddr, col_raddr;
  logic [ColorW-1:0]   col_wdata, col_rdata;

  logic                pick_found;
  logic [ColorW-1:0]   pick_color;
  logic                out_slot_free;
  logic                k_is_last;

  assign in_row_index = s_axis_tdata[VtxAddrW-1:0];
  assign in_row_bits  = s_axis_tdata[VtxAddrW +: RowW];
  assign s_axis_tready = (state_q == StLoad);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // Saturate the vertex count into 1..MaxVertices
  always_comb begin
    n_sat = vertex_count_q;
    if (vertex_count_q == '0) begin
      n_sat = CountW'(1);
    end else if (vertex_count_q > CountW'(MaxVertices)) begin
      n_sat = CountW'(MaxVertices);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_count_q <= VertexCountRst;
      color_count_q  <= ColorCountRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        RegVertexCount: vertex_count_q <= cfg_data_i;
        RegColorCount:  color_count_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Lowest free color in [start, m]
  always_comb begin
    pick_found = 1'b0;
    pick_color = '0;
    for (int c = NumColors - 1; c >= 1; c--) begin
      if (!forbid_q[c] && ((ColorW+1)'(c) >= start_q) &&
          (ColorW'(c) <= color_count_q)) begin
        pick_found = 1'b1;
        pick_color = ColorW'(c);
      end
    end
  end

  assign out_slot_free = !out_valid_q || m_axis_tready;
  assign k_is_last     = ({1'b0, k_q} == (n_q - CountW'(1)));

  always_comb begin
    state_d  = state_q;
    n_d      = n_q;
    v_d      = v_q;
    i_d      = i_q;
    k_d      = k_q;
    row_d    = row_q;
    start_d  = start_q;
    forbid_d = forbid_q;
    solved_d = solved_q;

    out_valid_d  = out_valid_q & ~m_axis_tready;
    out_vertex_d = out_vertex_q;
    out_color_d  = out_color_q;
    out_solved_d = out_solved_q;
    out_last_d   = out_last_q;

    adj_we    = 1'b0;
    adj_raddr = v_q[VtxAddrW-1:0];
    col_we    = 1'b0;
    col_waddr = v_q[VtxAddrW-1:0];
    col_wdata = '0;
    col_raddr = k_q;

    case (state_q)
      StLoad: begin
        adj_we = in_fire;
        if (in_fire && s_axis_tlast) begin
          n_d     = n_sat;
          v_d     = '0;
          i_d     = '0;
          state_d = StClear;
        end
      end
      StClear: begin
        col_we    = 1'b1;
        col_waddr = i_q;
        i_d       = i_q + VtxAddrW'(1);
        if (i_q == VtxLast) begin
          state_d = StEnter;
        end
      end
      StEnter: begin
        col_raddr = v_q[VtxAddrW-1:0];
        if (v_q == n_q) begin
          solved_d = 1'b1;
          k_d      = '0;
          state_d  = StORead;
        end else begin
          state_d = StFetch;
        end
      end
      StFetch: begin
        row_d     = adj_rdata;
        start_d   = {1'b0, col_rdata} + (ColorW+1)'(1);
        forbid_d  = '0;
        i_d       = '0;
        col_raddr = '0;
        state_d   = StScan;
      end
      StScan: begin
        // Own color counts as cleared, so skip the vertex itself
        col_raddr = i_q + VtxAddrW'(1);
        if (row_q[i_q] && (i_q != v_q[VtxAddrW-1:0])) begin
          forbid_d[col_rdata] = 1'b1;
        end
        i_d = i_q + VtxAddrW'(1);
        if ({1'b0, i_q} == (n_q - CountW'(1))) begin
          state_d = StPick;
        end
      end
      StPick: begin
        col_we    = 1'b1;
        col_wdata = pick_found ? pick_color : '0;
        if (pick_found) begin
          v_d     = v_q + CountW'(1);
          state_d = StEnter;
        end else if (v_q == '0) begin
          solved_d = 1'b0;
          k_d      = '0;
          state_d  = StOLoad;
        end else begin
          v_d     = v_q - CountW'(1);
          state_d = StEnter;
        end
      end
      StORead: begin
        state_d = StOLoad;
      end
      StOLoad: begin
        if (out_slot_free) begin
          out_valid_d = 1'b1;
          if (solved_q) begin
            out_vertex_d = k_q;
            out_color_d  = col_rdata;
            out_solved_d = 1'b1;
            out_last_d   = k_is_last;
            k_d          = k_q + VtxAddrW'(1);
            state_d      = k_is_last ? StLoad : StORead;
          end else begin
            out_vertex_d = '0;
            out_color_d  = '0;
            out_solved_d = 1'b0;
            out_last_d   = 1'b1;
            state_d      = StLoad;
          end
        end
      end
      default: begin
        state_d = StLoad;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      n_q         <= VertexCountRst;
      v_q         <= '0;
      i_q         <= '0;
      k_q         <= '0;
      solved_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      n_q         <= n_d;
      v_q         <= v_d;
      i_q         <= i_d;
      k_q         <= k_d;
      solved_q    <= solved_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    row_q        <= row_d;
    start_q      <= start_d;
    forbid_q     <= forbid_d;
    out_vertex_q <= out_vertex_d;
    out_color_q  <= out_color_d;
    out_solved_q <= out_solved_d;
    out_last_q   <= out_last_d;
  end

  gmcb_ram #(
    .Width (RowW),
    .Depth (MaxVertices)
  ) u_adj_ram (
    .clk_i   (clk_i),
    .we_i    (adj_we),
    .waddr_i (in_row_index),
    .wdata_i (in_row_bits),
    .raddr_i (adj_raddr),
    .rdata_o (adj_rdata)
  );

  gmcb_ram #(
    .Width (ColorW),
    .Depth (MaxVertices)
  ) u_col_ram (
    .clk_i   (clk_i),
    .we_i    (col_we),
    .waddr_i (col_waddr),
    .wdata_i (col_wdata),
    .raddr_i (col_raddr),
    .rdata_o (col_rdata)
  );

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {(OutDataW - VtxAddrW - ColorW)'(0), out_color_q, out_vertex_q};
  assign m_axis_tuser  = out_solved_q;
  assign m_axis_tlast  = out_last_q;

  `include "graph_m_coloring_backtrack_assert.svh"

  `GMCB_ASSERT_NOW(a_vertex_in_range, state_q != StLoad, v_q <= n_q,
    "search vertex beyond vertex count")
  `GMCB_ASSERT_NEXT(a_fail_to_output, (state_q == StPick) && !pick_found && (v_q == '0),
    (state_q == StOLoad) && !solved_q, "exhausted search did not report failure")
  `GMCB_ASSERT_NOW(a_fail_is_last, m_axis_tvalid && !m_axis_tuser,
    m_axis_tlast && (m_axis_tdata == '0), "failure beat must be a single zero beat")
  `GMCB_ASSERT_NEXT(a_no_overwrite, (state_q == StOLoad) && out_valid_q && !m_axis_tready,
    out_valid_q && $stable(m_axis_tdata), "pending output beat overwritten")

endmodule

@@ tb/sv/graph_m_coloring_backtrack_test.sv @@
// ----------------------------------------------------------------------------
// graph_m_coloring_backtrack_test
// Streams adjacency rows into the m-coloring search block and checks every
// color beat against an in-bench backtracking search or a fixed expected beat,
// over several vertex and color counts and with idle gaps on both stream sides.
// ----------------------------------------------------------------------------
module graph_m_coloring_backtrack_test;
  import gmcb_pkg::*;

  localparam int ClkPeriod   = 8;
  localparam int VisitCap    = 600;
  localparam int PhaseItems  = 35;
  localparam int NumPhases   = 8;
  localparam int DrainCycles = 40;
  localparam int MaxReports  = 40;

  typedef logic [RowW-1:0]   adj_mem_t [MaxVertices];
  typedef logic [ColorW-1:0] color_mem_t [MaxVertices];

  typedef struct packed {
    logic [VtxAddrW-1:0] vertex;
    logic [ColorW-1:0]   color;
    logic                solved;
    logic                last;
  } color_beat_t;

  typedef enum logic {StimCfg, StimRow} stim_kind_e;
  typedef enum int {GroupFrame, GroupBroken, GroupNoise} group_kind_e;

  typedef struct packed {
    stim_kind_e          kind;
    logic [CfgIdxW-1:0]  reg_idx;
    logic [CountW-1:0]   reg_val;
    logic [VtxAddrW-1:0] row;
    logic [RowW-1:0]     bits;
    logic                last;
    logic                typed;
    color_beat_t         want;
  } stim_row_t;

  localparam color_beat_t NoBeat   = '0;
  localparam color_beat_t FailBeat = '{vertex: 4'd0, color: 5'd0, solved: 1'b0, last: 1'b1};
  localparam color_beat_t LoneBeat = '{vertex: 4'd0, color: 5'd1, solved: 1'b1, last: 1'b1};

  localparam int PlanLen = 28;
  // K4 first (no 3-coloring after reset), then a self-loop with stray high
  // bits, zero colors, a saturated vertex count, and a 16-vertex frame of
  // mostly full rows that needs all 16 colors.
  localparam stim_row_t DirectedPlan [PlanLen] = '{
    '{StimRow, RegVertexCount, 5'd0,  4'd0,  16'h000E, 1'b0, 1'b0, NoBeat},
    '{StimRow, RegVertexCount, 5'd0,  4'd1,  16'h000D, 1'b0, 1'b0, NoBeat},
    '{StimRow, RegVertexCount, 5'd0,  4'd2,  16'h000B, 1'b0, 1'b0, NoBeat},
    '{StimRow, RegVertexCount, 5'd0,  4'd3,  16'h0007, 1'b1, 1'b1, FailBeat},
    '{StimCfg, RegColorCount,  5'd4,  4'd0,  16'h0000, 1'b0, 1'b0, NoBeat},
    '{StimRow, RegVertexCount, 5'd0,  4'd3,  16'hFFFF, 1'b1, 1'b0, NoBeat},
    '{StimCfg, RegColorCount,  5'd0,  4'd0,  16'h0000, 1'b0, 1'b0, NoBeat},
    '{StimRow, RegVertexCount, 5'd0,  4'd15, 16'h0000, 1'b1, 1'b1, FailBeat},
    '{StimCfg, RegVertexCount, 5'd0,  4'd0,  16'h0000, 1'b0, 1'b0, NoBeat},
    '{StimCfg, RegColorCount,  5'd31, 4'd0,  16'h0000, 1'b0, 1'b0, NoBeat},
    '{StimRow, RegVertexCount, 5'd0,  4'd5,  16'hFFFF, 1'b1, 1'b1, LoneBeat},
    '{StimCfg, RegVertexCount, 5'd16, 4'd0,  16'h0000, 1'b0, 1'b0, NoBeat},
    '{StimCfg, RegColorCount,  5'd16, 4'd0,  16'h0000, 1'b0, 1'b0, NoBeat},
    '{StimRow, RegVertexCount, 5'd0,  4'd4,  16'hFFFF, 1'b0, 1'b0, NoBeat},
    '{StimRow, RegVertexCount, 5'd0,  4'd5,  16'hFFFF, 1'b0, 1'b0, NoBeat},
    '{StimRow, RegVertexCount, 5'd0,  4'd6,  16'hFFFF, 1'b0, 1'b0, NoBeat},
    '{StimRow, RegVertexCount, 5'd0,  4'd7,  16'hFFFF, 1'b0, 1'b0, NoBeat},
    '{StimRow, RegVertexCount, 5'd0,  4'd8,  16'hFFFF, 1'b0, 1'b0, NoBeat},
    '{StimRow, RegVertexCount, 5'd0,  4'd9,  16'hFFFF, 1'b0, 1'b0, NoBeat},
    '{StimRow, RegVertexCount, 5'd0,  4'd10, 16'hFFFF, 1'b0, 1'b0, NoBeat},
    '{StimRow, RegVertexCount, 5'd0,  4'd11, 16'hFFFF, 1'b0, 1'b0, NoBeat},
    '{StimRow, RegVertexCount, 5'd0,  4'd12, 16'hFFFF, 1'b0, 1'b0, NoBeat},
    '{StimRow, RegVertexCount, 5'd0,  4'd13, 16'hFFFF, 1'b0, 1'b0, NoBeat},
    '{StimRow, RegVertexCount, 5'd0,  4'd14, 16'hFFFF, 1'b0, 1'b0, NoBeat},
    '{StimRow, RegVertexCount, 5'd0,  4'd15, 16'hFFFF, 1'b1, 1'b0, NoBeat},
    '{StimCfg, RegVertexCount, 5'd31, 4'd0,  16'h0000, 1'b0, 1'b0, NoBeat},
    '{StimCfg, RegColorCount,  5'd1,  4'd0,  16'h0000, 1'b0, 1'b0, NoBeat},
    '{StimRow, RegVertexCount, 5'd0,  4'd0,  16'h0000, 1'b1, 1'b0, NoBeat}
  };

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [OutDataW-1:0]  m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 m_axis_tlast;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CfgIdxW-1:0]   cfg_index_i   = '0;
  logic [CountW-1:0]    cfg_data_i    = '0;

  adj_mem_t             adj_model;
  logic [CountW-1:0]    vcount_model  = VertexCountRst;
  logic [CountW-1:0]    ccount_model  = ColorCountRst;
  color_beat_t          color_expect_q [$];
  int                   error_count   = 0;
  int                   sender_idle_pct    = 0;
  int                   receiver_stall_pct = 0;
  longint               cycle_budget  = 20000;

  graph_m_coloring_backtrack u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  function automatic int used_vertex_count(input logic [CountW-1:0] vc);
    if (vc == 0) return 1;
    if (vc > MaxVertices) return MaxVertices;
    return int'(vc);
  endfunction

  // Depth-first search, vertices in order, colors tried upward. Returns the
  // number of vertex visits; gives up once the visits pass visit_cap.
  function automatic int search_coloring(input adj_mem_t adj, input int nv, input int nc,
                                         input int visit_cap, output bit found,
                                         output color_mem_t col);
    int v;
    int c;
    int visits;
    bit placed;
    bit clash;
    v = 0;
    visits = 0;
    found = 1'b0;
    foreach (col[i]) col[i] = '0;
    while (visits <= visit_cap) begin
      if (v >= nv) begin
        found = 1'b1;
        return visits;
      end
      visits++;
      c = int'(col[v]) + 1;
      col[v] = '0;
      placed = 1'b0;
      while (!placed && c <= nc) begin
        clash = 1'b0;
        for (int i = 0; i < nv; i++)
          if (adj[v][i] && int'(col[i]) == c) clash = 1'b1;
        if (clash) begin
          c++;
        end else begin
          col[v] = c[ColorW-1:0];
          placed = 1'b1;
        end
      end
      if (placed) v++;
      else if (v == 0) return visits;
      else v--;
    end
    return visits;
  endfunction

  function automatic logic [RowW-1:0] sparse_row(input int density);
    logic [RowW-1:0] r;
    for (int b = 0; b < RowW; b++) r[b] = ($urandom_range(0, 99) < density);
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    if (error_count < MaxReports) $display("[%0t] mismatch: %s", $time, what);
    error_count++;
  endtask

  // Store the row in the model; a final row runs the search and queues beats.
  task automatic predict_row(input logic [VtxAddrW-1:0] row, input logic [RowW-1:0] bits,
                             input logic last, input bit typed, input color_beat_t want);
    int nv;
    int visits;
    bit found;
    color_mem_t col;
    color_beat_t beat;
    adj_model[row] = bits;
    if (!last) return;
    nv = used_vertex_count(vcount_model);
    visits = search_coloring(adj_model, nv, int'(ccount_model), 1 << 30, found, col);
    cycle_budget += 4 * (32 + visits * (3 + nv) + nv * 40);
    if (typed) begin
      color_expect_q.push_back(want);
    end else if (!found) begin
      color_expect_q.push_back(FailBeat);
    end else begin
      for (int i = 0; i < nv; i++) begin
        beat.vertex = VtxAddrW'(i);
        beat.color  = col[i];
        beat.solved = 1'b1;
        beat.last   = (i == nv - 1);
        color_expect_q.push_back(beat);
      end
    end
  endtask

  task automatic send_row(input logic [VtxAddrW-1:0] row, input logic [RowW-1:0] bits,
                          input logic last, input bit typed, input color_beat_t want);
    cfg_valid_i <= 1'b0;
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    predict_row(row, bits, last, typed, want);
    cycle_budget += 200;
    s_axis_tdata  <= {{(InDataW - RowW - VtxAddrW){1'b0}}, bits, row};
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high; the next row beat or drain drops it.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CountW-1:0] val);
    if (idx == RegVertexCount) vcount_model = val;
    else ccount_model = val;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    cfg_valid_i   <= 1'b0;
    cycle_budget  += 2 * DrainCycles;
    @(posedge clk_i);
    while (color_expect_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // One random group: a full frame, a broken frame or stray rows. Groups that
  // would start a search are retried sparser until the search stays short.
  task automatic play_group(output int group_len);
    group_kind_e kind;
    int nv;
    int density;
    int tries;
    int pick;
    int swap;
    int visits;
    bit found;
    bit starts_search;
    color_mem_t col;
    adj_mem_t trial;
    logic [RowW-1:0] sym [MaxVertices];
    logic [RowW-1:0] low_mask;
    int order [MaxVertices];
    logic [VtxAddrW-1:0] grp_row [MaxVertices];
    logic [RowW-1:0] grp_bits [MaxVertices];
    pick = $urandom_range(0, 99);
    kind = (pick < 70) ? GroupFrame : (pick < 85) ? GroupBroken : GroupNoise;
    nv = used_vertex_count(vcount_model);
    low_mask = RowW'((32'd1 << nv) - 1);
    density = $urandom_range(10, 70);
    tries = 0;
    forever begin
      starts_search = (kind != GroupNoise);
      case (kind)
        GroupFrame: begin
          group_len = nv;
          foreach (sym[i]) sym[i] = '0;
          for (int i = 0; i < nv; i++)
            for (int j = 0; j < i; j++)
              if ($urandom_range(0, 99) < density) begin
                sym[i][j] = 1'b1;
                sym[j][i] = 1'b1;
              end
          for (int i = 0; i < nv; i++) begin
            order[i] = i;
            if ($urandom_range(0, 3) == 0) sym[i] |= sparse_row(50) & ~low_mask;
            if ($urandom_range(0, 7) == 0) sym[i][i] = 1'b1;
          end
          for (int k = nv - 1; k > 0; k--) begin
            pick = $urandom_range(0, k);
            swap = order[k];
            order[k] = order[pick];
            order[pick] = swap;
          end
          for (int k = 0; k < nv; k++) begin
            grp_row[k]  = VtxAddrW'(order[k]);
            grp_bits[k] = sym[order[k]];
          end
        end
        GroupBroken: begin
          group_len = $urandom_range(1, 4);
          for (int k = 0; k < group_len; k++) begin
            grp_row[k]  = VtxAddrW'($urandom_range(0, MaxVertices - 1));
            grp_bits[k] = sparse_row(density);
          end
        end
        default: begin
          group_len = $urandom_range(1, 3);
          for (int k = 0; k < group_len; k++) begin
            grp_row[k]  = VtxAddrW'($urandom_range(0, MaxVertices - 1));
            grp_bits[k] = RowW'($urandom);
          end
        end
      endcase
      if (!starts_search) break;
      trial = adj_model;
      for (int k = 0; k < group_len; k++) trial[grp_row[k]] = grp_bits[k];
      visits = search_coloring(trial, nv, int'(ccount_model), VisitCap, found, col);
      if (visits <= VisitCap) break;
      // An edgeless frame always finishes in one pass.
      tries++;
      density = (tries >= 6) ? 0 : density / 2;
      if (tries >= 6) kind = GroupFrame;
    end
    for (int k = 0; k < group_len; k++)
      send_row(grp_row[k], grp_bits[k], starts_search && (k == group_len - 1), 1'b0, NoBeat);
  endtask

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);

  always @(posedge clk_i) begin : color_check
    color_beat_t got;
    color_beat_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = '{vertex: m_axis_tdata[3:0], color: m_axis_tdata[8:4],
              solved: m_axis_tuser, last: m_axis_tlast};
      if (color_expect_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat vertex %0d color %0d solved %0b last %0b",
                                  got.vertex, got.color, got.solved, got.last));
      end else begin
        want = color_expect_q.pop_front();
        if (got.vertex !== want.vertex)
          report_mismatch($sformatf("vertex %0d, want %0d", got.vertex, want.vertex));
        if (got.color !== want.color)
          report_mismatch($sformatf("vertex %0d color %0d, want %0d",
                                    want.vertex, got.color, want.color));
        if (got.solved !== want.solved)
          report_mismatch($sformatf("vertex %0d solved %0b, want %0b",
                                    want.vertex, got.solved, want.solved));
        if (got.last !== want.last)
          report_mismatch($sformatf("vertex %0d last %0b, want %0b",
                                    want.vertex, got.last, want.last));
      end
    end
  end

  initial begin : watchdog
    longint cycles;
    cycles = 0;
    while (cycles < cycle_budget) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("graph_m_coloring_backtrack_test: errors");
    $finish;
  end

  initial begin : stimulus
    int phase_items;
    int group_len;
    logic [CountW-1:0] vc_pick;
    logic [CountW-1:0] cc_pick;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (DirectedPlan[i]) begin
      if (DirectedPlan[i].kind == StimCfg) begin
        if (i == 0 || DirectedPlan[i - 1].kind != StimCfg) drain_results();
        write_reg(DirectedPlan[i].reg_idx, DirectedPlan[i].reg_val);
      end else begin
        send_row(DirectedPlan[i].row, DirectedPlan[i].bits, DirectedPlan[i].last,
                 DirectedPlan[i].typed, DirectedPlan[i].want);
      end
    end

    // Every row has been written above, so any vertex count is safe from here.
    for (int p = 0; p < NumPhases; p++) begin
      drain_results();
      case (p % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 45; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 45; end
        default: begin sender_idle_pct = 31; receiver_stall_pct = 31; end
      endcase
      case (p)
        0: begin vc_pick = 5'd16; cc_pick = 5'd31; end
        1: begin vc_pick = 5'd1;  cc_pick = 5'd1;  end
        2: begin vc_pick = 5'd0;  cc_pick = 5'd0;  end
        3: begin vc_pick = 5'd31; cc_pick = 5'd16; end
        default: begin
          vc_pick = ($urandom_range(0, 3) == 0) ? CountW'($urandom_range(9, 16))
                                                : CountW'($urandom_range(2, 8));
          cc_pick = CountW'($urandom_range(1, 5));
        end
      endcase
      write_reg(RegVertexCount, vc_pick);
      write_reg(RegColorCount, cc_pick);
      phase_items = 0;
      while (phase_items < PhaseItems) begin
        play_group(group_len);
        phase_items += group_len;
      end
    end

    drain_results();
    if (error_count == 0) begin
      $display("graph_m_coloring_backtrack_test: clean");
    end else begin
      $display("graph_m_coloring_backtrack_test: errors");
    end
    $finish;
  end

endmodule
